// File: rtl/tsb_pkg.sv
// shared constants and handshake types for the triangle strip builder
package tsb_pkg;

   // input function codes
   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   // result queue depth and the width of its free-slot count
   localparam int OUT_DEPTH = 4;
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   // head of the command queue as seen by the strip engine
   typedef struct packed {
      logic valid;
      logic flush;
   } cmd_status_type;

   // one strip entry leaving the engine
   typedef struct packed {
      logic push;
      logic last;
   } rsp_push_type;

endpackage

// File: rtl/tsb_front.sv
// input side: accepts items, sorts flush from add and queues them for the engine
module tsb_front
   import tsb_pkg::*;
#(
   parameter int INDEX_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_func,
   input  logic [INDEX_BITS-1:0] req_vertex_a,
   input  logic [INDEX_BITS-1:0] req_vertex_b,
   input  logic [INDEX_BITS-1:0] req_vertex_c,
   input  logic                  cmd_pop,
   output cmd_status_type        cmd_st,
   output logic [INDEX_BITS-1:0] cmd_a,
   output logic [INDEX_BITS-1:0] cmd_b,
   output logic [INDEX_BITS-1:0] cmd_c
);

   localparam int IN_DEPTH = 2;
   localparam int IN_AW    = $clog2(IN_DEPTH);
   localparam int IN_CW    = $clog2(IN_DEPTH + 1);

   logic                  q_flush_ff [IN_DEPTH];
   logic [INDEX_BITS-1:0] q_a_ff     [IN_DEPTH];
   logic [INDEX_BITS-1:0] q_b_ff     [IN_DEPTH];
   logic [INDEX_BITS-1:0] q_c_ff     [IN_DEPTH];
   logic [IN_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [IN_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [IN_CW-1:0]      count_ff, count_in;
   logic                  push;
   logic                  pop;

   assign req_full = (count_ff == IN_CW'(IN_DEPTH));
   assign push     = req_push && !req_full;
   assign pop      = cmd_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IN_AW'(IN_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IN_AW'(IN_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_flush_ff[wr_ptr_ff] <= (req_func == FUNC_FLUSH);
         q_a_ff[wr_ptr_ff]     <= req_vertex_a;
         q_b_ff[wr_ptr_ff]     <= req_vertex_b;
         q_c_ff[wr_ptr_ff]     <= req_vertex_c;
      end
   end

   assign cmd_st.valid = (count_ff != '0);
   assign cmd_st.flush = q_flush_ff[rd_ptr_ff];
   assign cmd_a        = q_a_ff[rd_ptr_ff];
   assign cmd_b        = q_b_ff[rd_ptr_ff];
   assign cmd_c        = q_c_ff[rd_ptr_ff];

endmodule

// File: rtl/tsb_engine.sv
// strip engine: attach decision, strip storage and draining of finished strips
module tsb_engine
   import tsb_pkg::*;
#(
   parameter int MAX_STRIP  = 30,
   parameter int INDEX_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_status_type        cmd_st,
   input  logic [INDEX_BITS-1:0] cmd_a,
   input  logic [INDEX_BITS-1:0] cmd_b,
   input  logic [INDEX_BITS-1:0] cmd_c,
   output logic                  cmd_pop,
   input  logic [OUT_CNT_W-1:0]  out_free,
   output rsp_push_type          rsp_push,
   output logic [INDEX_BITS-1:0] rsp_vertex
);

   localparam int LEN_W   = $clog2(MAX_STRIP + 1);
   localparam int ADDR_W  = $clog2(MAX_STRIP);
   localparam int HEAD_N  = 5;
   localparam int HEAD_AW = $clog2(HEAD_N);

   typedef enum logic [1:0] {
      ST_DECIDE = 2'b01,
      ST_DRAIN  = 2'b10
   } engine_state_type;

   // first five entries live in flops, the rest in the strip memory
   logic [INDEX_BITS-1:0] head_ff [HEAD_N];
   logic [INDEX_BITS-1:0] head_in [HEAD_N];
   logic [INDEX_BITS-1:0] strip_mem [MAX_STRIP];

   engine_state_type      state_ff, state_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [LEN_W-1:0]      k_ff, k_in;
   logic [INDEX_BITS-1:0] prev_ff, prev_in;   // entry at len-2
   logic [INDEX_BITS-1:0] last_ff, last_in;   // entry at len-1

   logic                  rd_valid_ff;
   logic                  rd_last_ff;
   logic                  from_head_ff;
   logic [INDEX_BITS-1:0] head_rd_ff;
   logic [INDEX_BITS-1:0] mem_rd_ff;

   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_wa;
   logic [INDEX_BITS-1:0] mem_wd;
   logic                  issue;
   logic                  issue_last;
   logic [HEAD_AW-1:0]    head_sel;

   logic                  is_len3, is_len4, is_open;
   logic [INDEX_BITS-1:0] e0, e1;
   logic                  em_hit;
   logic [INDEX_BITS-1:0] em_nv;
   logic [2:0]            t_hit;
   logic [INDEX_BITS-1:0] t_nv [3];
   logic [2:0]            rot_sel;
   logic                  rot_hit;
   logic [INDEX_BITS-1:0] rot_nv;
   logic                  reo_hit;
   logic [INDEX_BITS-1:0] reo_nv;

   assign is_len3 = (len_ff == LEN_W'(3));
   assign is_len4 = (len_ff == LEN_W'(4));
   assign is_open = (len_ff > LEN_W'(4)) && (len_ff < LEN_W'(MAX_STRIP));

   // open edge direction flips with strip parity
   assign e0 = len_ff[0] ? last_ff : prev_ff;
   assign e1 = len_ff[0] ? prev_ff : last_ff;

   always_comb begin
      em_hit = 1'b1;
      em_nv  = cmd_c;
      if (cmd_a == e0 && cmd_b == e1) begin
         em_nv = cmd_c;
      end else if (cmd_b == e0 && cmd_c == e1) begin
         em_nv = cmd_a;
      end else if (cmd_c == e0 && cmd_a == e1) begin
         em_nv = cmd_b;
      end else begin
         em_hit = 1'b0;
      end
   end

   // single triangle: try each of its edges, head entry 3 repeats entry 0
   always_comb begin
      for (int p = 0; p < 3; p++) begin
         t_hit[p] = 1'b1;
         t_nv[p]  = cmd_a;
         if (head_ff[p] == cmd_a && head_ff[p+1] == cmd_c) begin
            t_nv[p] = cmd_b;
         end else if (head_ff[p] == cmd_b && head_ff[p+1] == cmd_a) begin
            t_nv[p] = cmd_c;
         end else if (head_ff[p] == cmd_c && head_ff[p+1] == cmd_b) begin
            t_nv[p] = cmd_a;
         end else begin
            t_hit[p] = 1'b0;
         end
      end
   end

   always_comb begin
      rot_hit = |t_hit;
      rot_sel = 3'b000;
      rot_nv  = t_nv[0];
      if (t_hit[0]) begin
         rot_sel = 3'b001;
         rot_nv  = t_nv[0];
      end else if (t_hit[1]) begin
         rot_sel = 3'b010;
         rot_nv  = t_nv[1];
      end else if (t_hit[2]) begin
         rot_sel = 3'b100;
         rot_nv  = t_nv[2];
      end
   end

   // four entries: attach on the far side by duplicating the first vertex
   always_comb begin
      reo_hit = 1'b1;
      reo_nv  = cmd_a;
      if (cmd_b == head_ff[3] && cmd_c == head_ff[1]) begin
         reo_nv = cmd_a;
      end else if (cmd_a == head_ff[1] && cmd_c == head_ff[3]) begin
         reo_nv = cmd_b;
      end else if (cmd_a == head_ff[3] && cmd_b == head_ff[1]) begin
         reo_nv = cmd_c;
      end else begin
         reo_hit = 1'b0;
      end
   end

   assign issue_last = (k_ff == len_ff - 1'b1);
   assign head_sel   = (k_ff < LEN_W'(HEAD_N)) ? k_ff[HEAD_AW-1:0] : '0;

   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      k_in     = k_ff;
      prev_in  = prev_ff;
      last_in  = last_ff;
      for (int i = 0; i < HEAD_N; i++) begin
         head_in[i] = head_ff[i];
      end
      cmd_pop = 1'b0;
      mem_we  = 1'b0;
      mem_wa  = len_ff[ADDR_W-1:0];
      mem_wd  = em_nv;
      issue   = 1'b0;

      case (state_ff)
         ST_DECIDE: begin
            if (cmd_st.valid) begin
               if (cmd_st.flush) begin
                  if (len_ff != '0) begin
                     state_in = ST_DRAIN;
                     k_in     = '0;
                  end else begin
                     cmd_pop = 1'b1;
                  end
               end else if (is_len3 && rot_hit) begin
                  if (rot_sel[0]) begin
                     head_in[0] = head_ff[2];
                     head_in[1] = head_ff[0];
                     head_in[2] = head_ff[1];
                     prev_in    = head_ff[1];
                  end else if (rot_sel[2]) begin
                     head_in[0] = head_ff[1];
                     head_in[1] = head_ff[2];
                     head_in[2] = head_ff[0];
                     prev_in    = head_ff[0];
                  end else begin
                     prev_in    = head_ff[2];
                  end
                  head_in[3] = rot_nv;
                  last_in    = rot_nv;
                  len_in     = LEN_W'(4);
                  cmd_pop    = 1'b1;
               end else if (is_len4 && reo_hit) begin
                  // x y z w becomes x x z y w, then the new vertex
                  head_in[4] = head_ff[3];
                  head_in[3] = head_ff[1];
                  head_in[1] = head_ff[0];
                  mem_we     = 1'b1;
                  mem_wa     = ADDR_W'(HEAD_N);
                  mem_wd     = reo_nv;
                  prev_in    = head_ff[3];
                  last_in    = reo_nv;
                  len_in     = LEN_W'(HEAD_N + 1);
                  cmd_pop    = 1'b1;
               end else if ((is_len4 || is_open) && em_hit) begin
                  if (is_len4) begin
                     head_in[4] = em_nv;
                  end else begin
                     mem_we = 1'b1;
                  end
                  prev_in = last_ff;
                  last_in = em_nv;
                  len_in  = len_ff + 1'b1;
                  cmd_pop = 1'b1;
               end else if (len_ff == '0) begin
                  head_in[0] = cmd_a;
                  head_in[1] = cmd_b;
                  head_in[2] = cmd_c;
                  head_in[3] = cmd_a;
                  prev_in    = cmd_b;
                  last_in    = cmd_c;
                  len_in     = LEN_W'(3);
                  cmd_pop    = 1'b1;
               end else begin
                  state_in = ST_DRAIN;
                  k_in     = '0;
               end
            end
         end
         ST_DRAIN: begin
            // keep room in the result queue for the read still in flight
            if (out_free > OUT_CNT_W'(rd_valid_ff)) begin
               issue = 1'b1;
               k_in  = k_ff + 1'b1;
               if (issue_last) begin
                  state_in = ST_DECIDE;
                  len_in   = '0;
                  cmd_pop  = 1'b1;
                  if (!cmd_st.flush) begin
                     head_in[0] = cmd_a;
                     head_in[1] = cmd_b;
                     head_in[2] = cmd_c;
                     head_in[3] = cmd_a;
                     prev_in    = cmd_b;
                     last_in    = cmd_c;
                     len_in     = LEN_W'(3);
                  end
               end
            end
         end
         default: begin
            state_in = ST_DECIDE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_DECIDE;
         len_ff      <= '0;
         k_ff        <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         len_ff      <= len_in;
         k_ff        <= k_in;
         rd_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      last_ff <= last_in;
      for (int i = 0; i < HEAD_N; i++) begin
         head_ff[i] <= head_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         strip_mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         mem_rd_ff    <= strip_mem[k_ff[ADDR_W-1:0]];
         head_rd_ff   <= head_ff[head_sel];
         from_head_ff <= (k_ff < LEN_W'(HEAD_N));
         rd_last_ff   <= issue_last;
      end
   end

   assign rsp_push.push = rd_valid_ff;
   assign rsp_push.last = rd_last_ff;
   assign rsp_vertex    = from_head_ff ? head_rd_ff : mem_rd_ff;

`ifndef SYNTHESIS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_STRIP))
      else $error("strip length beyond capacity");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> len_ff != '0)
      else $error("draining an empty strip");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> out_free != '0)
      else $error("strip entry pushed into a full result queue");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_st.valid)
      else $error("command popped from an empty queue");

   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      issue && issue_last |=> state_ff == ST_DECIDE)
      else $error("drain did not end after the final entry");
`endif

endmodule

// File: rtl/tsb_rsp_queue.sv
// result queue holding emitted strip entries until they are popped
module tsb_rsp_queue
   import tsb_pkg::*;
#(
   parameter int INDEX_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rsp_push_type          rsp_push,
   input  logic [INDEX_BITS-1:0] rsp_vertex,
   output logic [OUT_CNT_W-1:0]  out_free,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [INDEX_BITS-1:0] rsp_vertex_index,
   output logic                  rsp_last_in_strip
);

   localparam int OUT_AW = $clog2(OUT_DEPTH);

   logic [INDEX_BITS-1:0] q_vertex_ff [OUT_DEPTH];
   logic                  q_last_ff   [OUT_DEPTH];
   logic [OUT_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [OUT_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [OUT_CNT_W-1:0]  count_ff, count_in;
   logic                  pop;

   assign rsp_empty = (count_ff == '0);
   assign pop       = rsp_pop && !rsp_empty;
   assign out_free  = OUT_CNT_W'(OUT_DEPTH) - count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (rsp_push.push) begin
         wr_ptr_in = (wr_ptr_ff == OUT_AW'(OUT_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == OUT_AW'(OUT_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (rsp_push.push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !rsp_push.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push.push) begin
         q_vertex_ff[wr_ptr_ff] <= rsp_vertex;
         q_last_ff[wr_ptr_ff]   <= rsp_push.last;
      end
   end

   assign rsp_vertex_index  = q_vertex_ff[rd_ptr_ff];
   assign rsp_last_in_strip = q_last_ff[rd_ptr_ff];

endmodule

// File: rtl/triangle_strip_builder.sv
// Greedy triangle strip builder. Items enter through a two-entry queue
// (req_push/req_full); an add item carries three vertex indices, a flush item
// drains the strip. The strip engine decides whether a triangle attaches to
// the open edge of the current strip and appends its new vertex. A triangle
// that does not attach, or arrives with the strip at MAX_STRIP entries, first
// drains the old strip: one entry per cycle, while the result queue has room,
// is read from the strip store (first five entries in flops, the rest in a
// memory with one read port) into a four-entry result queue, and the new strip
// starts in the cycle of the final read. Results are read through rsp_empty/
// rsp_pop, with rsp_last_in_strip marking the final index of each strip; a
// flush of an empty strip gives no results. Stalls on the result side only
// hold up draining.
module triangle_strip_builder
   import tsb_pkg::*;
#(
   parameter int MAX_STRIP  = 30,
   parameter int INDEX_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_func,
   input  logic [INDEX_BITS-1:0] req_vertex_a,
   input  logic [INDEX_BITS-1:0] req_vertex_b,
   input  logic [INDEX_BITS-1:0] req_vertex_c,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [INDEX_BITS-1:0] rsp_vertex_index,
   output logic                  rsp_last_in_strip
);

   cmd_status_type        cmd_st;
   logic                  cmd_pop;
   logic [INDEX_BITS-1:0] cmd_a;
   logic [INDEX_BITS-1:0] cmd_b;
   logic [INDEX_BITS-1:0] cmd_c;
   logic [OUT_CNT_W-1:0]  out_free;
   rsp_push_type          rsp_push;
   logic [INDEX_BITS-1:0] rsp_vertex;

   tsb_front #(
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_func     (req_func),
      .req_vertex_a (req_vertex_a),
      .req_vertex_b (req_vertex_b),
      .req_vertex_c (req_vertex_c),
      .cmd_pop      (cmd_pop),
      .cmd_st       (cmd_st),
      .cmd_a        (cmd_a),
      .cmd_b        (cmd_b),
      .cmd_c        (cmd_c)
   );

   tsb_engine #(
      .MAX_STRIP  (MAX_STRIP),
      .INDEX_BITS (INDEX_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_st     (cmd_st),
      .cmd_a      (cmd_a),
      .cmd_b      (cmd_b),
      .cmd_c      (cmd_c),
      .cmd_pop    (cmd_pop),
      .out_free   (out_free),
      .rsp_push   (rsp_push),
      .rsp_vertex (rsp_vertex)
   );

   tsb_rsp_queue #(
      .INDEX_BITS (INDEX_BITS)
   ) u_rsp_queue (
      .clock             (clock),
      .reset             (reset),
      .rsp_push          (rsp_push),
      .rsp_vertex        (rsp_vertex),
      .out_free          (out_free),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_vertex_index  (rsp_vertex_index),
      .rsp_last_in_strip (rsp_last_in_strip)
   );

endmodule

// File: test/triangle_strip_builder_tb.sv
// testbench for the triangle strip builder: strip prediction, scoreboard and queue-side drivers
module triangle_strip_builder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tsb_pkg::*;

   localparam int STRIP_MAX = 30;
   localparam int N_ITEMS = 270;
   localparam int HOLD_AT = 60;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [31:0] vertex;
      logic        last;
   } strip_entry_type;

   // predicted strip state and the queue of strip entries still to come out
   class strip_scoreboard;
      logic [31:0]     strip [STRIP_MAX];
      int unsigned     strip_len;
      strip_entry_type expected_entries[$];
      int unsigned     errors;

      function new();
         strip_len = 0;
         errors = 0;
      endfunction

      function int pending();
         return expected_entries.size();
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= 10) $display("%0t ns: %s", $time, what);
      endfunction

      function void drain_strip();
         strip_entry_type e;
         for (int k = 0; k < strip_len; k++) begin
            e.vertex = strip[k];
            e.last = (k + 1 == strip_len);
            expected_entries.push_back(e);
         end
         strip_len = 0;
      endfunction

      // open edge direction flips with the parity of the strip length
      function bit open_edge_hit(input logic [31:0] a, b, c, output logic [31:0] nv);
         logic [31:0] e0, e1;
         nv = '0;
         if (strip_len % 2 == 1) begin
            e1 = strip[strip_len - 2];
            e0 = strip[strip_len - 1];
         end else begin
            e0 = strip[strip_len - 2];
            e1 = strip[strip_len - 1];
         end
         if (a == e0 && b == e1) begin
            nv = c;
            return 1'b1;
         end
         if (b == e0 && c == e1) begin
            nv = a;
            return 1'b1;
         end
         if (c == e0 && a == e1) begin
            nv = b;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_item(input logic func, input logic [31:0] a, b, c);
         logic [31:0] nv, x, y, z;
         bit hit;
         hit = 1'b0;
         nv = '0;
         if (func == FUNC_FLUSH) begin
            drain_strip();
            return;
         end
         if (strip_len > 4 && strip_len < STRIP_MAX) begin
            hit = open_edge_hit(a, b, c, nv);
         end else if (strip_len == 3) begin
            // first triangle: try each of its edges, rotate the match into place
            for (int p = 0; p < 3 && !hit; p++) begin
               if (strip[p] == a && strip[p + 1] == c) begin
                  nv = b;
                  hit = 1'b1;
               end else if (strip[p] == b && strip[p + 1] == a) begin
                  nv = c;
                  hit = 1'b1;
               end else if (strip[p] == c && strip[p + 1] == b) begin
                  nv = a;
                  hit = 1'b1;
               end
               if (hit) begin
                  x = strip[0];
                  y = strip[1];
                  z = strip[2];
                  if (p == 0) begin
                     strip[0] = z;
                     strip[1] = x;
                     strip[2] = y;
                  end else if (p == 2) begin
                     strip[0] = y;
                     strip[1] = z;
                     strip[2] = x;
                  end
               end
            end
         end else if (strip_len == 4) begin
            if (b == strip[3] && c == strip[1]) begin
               nv = a;
               hit = 1'b1;
            end else if (a == strip[1] && c == strip[3]) begin
               nv = b;
               hit = 1'b1;
            end else if (a == strip[3] && b == strip[1]) begin
               nv = c;
               hit = 1'b1;
            end
            if (hit) begin
               // x y z w becomes x x z y w
               strip[4] = strip[3];
               strip[3] = strip[1];
               strip[1] = strip[0];
               strip_len = 5;
            end else begin
               hit = open_edge_hit(a, b, c, nv);
            end
         end
         if (hit && strip_len < STRIP_MAX) begin
            strip[strip_len] = nv;
            strip_len++;
            return;
         end
         if (strip_len > 0) drain_strip();
         strip[0] = a;
         strip[1] = b;
         strip[2] = c;
         strip[3] = a;
         strip_len = 3;
      endfunction

      function void check_result(input logic [31:0] vertex, input logic last);
         strip_entry_type want;
         if (expected_entries.size() == 0) begin
            flag($sformatf("unexpected result vertex %h last %b", vertex, last));
            return;
         end
         want = expected_entries.pop_front();
         if (want.vertex !== vertex)
            flag($sformatf("vertex_index expected %h got %h", want.vertex, vertex));
         if (want.last !== last)
            flag($sformatf("last_in_strip expected %b got %b (vertex %h)",
                           want.last, last, vertex));
      endfunction

      function void close_out();
         if (expected_entries.size() != 0)
            flag($sformatf("%0d strip entries never came out", expected_entries.size()));
      endfunction

      // a triangle built to attach to the current strip in the chosen way
      function void attaching_triangle(input int variant, input logic [31:0] nv,
                                       output logic [31:0] a, b, c);
         logic [31:0] s0, s1;
         int p;
         a = nv;
         b = $urandom;
         c = $urandom;
         if (strip_len == 3) begin
            p = variant % 3;
            s0 = strip[p];
            s1 = strip[p + 1];
            case ((variant / 3) % 3)
               0: begin
                  a = s0; c = s1; b = nv;
               end
               1: begin
                  b = s0; a = s1; c = nv;
               end
               default: begin
                  c = s0; b = s1; a = nv;
               end
            endcase
         end else if (strip_len == 4 && variant % 4 != 3) begin
            case (variant % 4)
               0: begin
                  b = strip[3]; c = strip[1]; a = nv;
               end
               1: begin
                  a = strip[1]; c = strip[3]; b = nv;
               end
               default: begin
                  a = strip[3]; b = strip[1]; c = nv;
               end
            endcase
         end else if (strip_len >= 4) begin
            // from length four on, a triangle on the open edge; on a full strip it must not attach
            if (strip_len % 2 == 1) begin
               s1 = strip[strip_len - 2];
               s0 = strip[strip_len - 1];
            end else begin
               s0 = strip[strip_len - 2];
               s1 = strip[strip_len - 1];
            end
            case (variant % 3)
               0: begin
                  a = s0; b = s1; c = nv;
               end
               1: begin
                  b = s0; c = s1; a = nv;
               end
               default: begin
                  c = s0; a = s1; b = nv;
               end
            endcase
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_func = FUNC_ADD;
   logic [31:0] req_vertex_a = '0;
   logic [31:0] req_vertex_b = '0;
   logic [31:0] req_vertex_c = '0;
   logic        rsp_pop = 1'b0;
   logic        req_full;
   logic        rsp_empty;
   logic [31:0] rsp_vertex_index;
   logic        rsp_last_in_strip;

   strip_scoreboard book;
   int unsigned     items_sent = 0;
   bit              calm = 1'b0;
   bit              held = 1'b0;

   triangle_strip_builder #(
      .MAX_STRIP (STRIP_MAX),
      .INDEX_BITS(32)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_vertex_a     (req_vertex_a),
      .req_vertex_b     (req_vertex_b),
      .req_vertex_c     (req_vertex_c),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_last_in_strip(rsp_last_in_strip)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // mostly full-range values, some tiny ones so that vertices repeat
   function automatic logic [31:0] pick_vertex();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return $urandom_range(0, 7);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input logic func, input logic [31:0] a, b, c);
      req_push <= 1'b1;
      req_func <= func;
      req_vertex_a <= a;
      req_vertex_b <= b;
      req_vertex_c <= c;
      do @(posedge clock); while (req_full);
      book.note_item(func, a, b, c);
      items_sent++;
      if (items_sent >= N_ITEMS - 40) calm = 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic grow_strip(input int variant);
      logic [31:0] a, b, c;
      book.attaching_triangle(variant, pick_vertex(), a, b, c);
      send_item(FUNC_ADD, a, b, c);
   endtask

   task automatic random_triangle();
      send_item(FUNC_ADD, pick_vertex(), pick_vertex(), pick_vertex());
   endtask

   initial begin : stimulus
      int run;
      book = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_item(FUNC_FLUSH, '1, '1, '1);   // flush with nothing in the strip
      send_item(FUNC_ADD, '1, '1, '0);     // degenerate, two all-ones corners and one zero
      send_item(FUNC_FLUSH, '0, '0, '0);
      for (int k = 0; k < 3; k++) begin
         send_item(FUNC_ADD, $urandom, $urandom, $urandom);
         grow_strip(k * 4);                // each first-triangle edge and order
         grow_strip(k);                    // each duplicate-vertex reorder
      end
      send_item(FUNC_ADD, $urandom, $urandom, $urandom);
      grow_strip(0);
      grow_strip(3);                       // plain edge match at length four
      grow_strip(1);
      grow_strip(2);
      send_item(FUNC_FLUSH, $urandom, $urandom, $urandom);
      send_item(FUNC_ADD, $urandom, $urandom, $urandom);
      grow_strip(5);
      send_item(FUNC_ADD, $urandom, $urandom, $urandom);   // does not attach
      send_item(FUNC_FLUSH, '0, '0, '0);

      // well-formed strips of random length, long ones run past full
      while (items_sent < N_ITEMS) begin
         run = ($urandom_range(0, 3) == 0) ? 28 : $urandom_range(0, 10);
         random_triangle();
         for (int k = 0; k < run; k++) begin
            if ($urandom_range(0, 24) == 0) random_triangle();
            else if ($urandom_range(0, 29) == 0)
               send_item(FUNC_FLUSH, $urandom, $urandom, $urandom);
            else grow_strip($urandom_range(0, 8));
         end
         if ($urandom_range(0, 1) == 1) send_item(FUNC_FLUSH, $urandom, $urandom, $urandom);
      end
      send_item(FUNC_FLUSH, $urandom, $urandom, $urandom);
      req_push <= 1'b0;

      while (book.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      book.close_out();
      if (book.errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : result_sink
      do @(posedge clock); while (reset);
      forever begin
         if (!held && items_sent >= HOLD_AT) begin
            // long hold so the result and input queues back up
            held = 1'b1;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         book.check_result(rsp_vertex_index, rsp_last_in_strip);
   end

   initial begin : watchdog
      #1_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
